### rtl/core/lrc_pkg.sv
// lrc_pkg: shared types and constants for the least rotation check block.
// Holds the beat structs, the cell control struct and the field widths.
// No dependencies.
package lrc_pkg;

	localparam int unsigned ANGLE_BITS  = 16;
	localparam int unsigned INDEX_BITS  = 4;
	localparam int unsigned LENGTH_BITS = 5;
	localparam int unsigned MAX_LEN_DEF = 16;

	typedef struct packed {
		logic [ANGLE_BITS-1:0] angle;
		logic                  last;
	} item_t;

	typedef struct packed {
		logic                   is_least_at_start;
		logic [INDEX_BITS-1:0]  least_index;
		logic [LENGTH_BITS-1:0] word_length;
		logic                   too_long;
	} result_t;

	typedef struct packed {
		logic rot_a;
		logic rot_b;
		logic copy_b;
	} cell_ctl_t;

endpackage

### rtl/core/least_rotation_check.sv
// least_rotation_check: finds the least cyclic rotation of a word of angles.
// Top level: control sequencer and the chain of lrc_cell positions.
// Depends on lrc_pkg and lrc_cell.
//
//   channel  | valid         | stall          | payload
//   ---------+---------------+----------------+----------------------------
//   item     | item_valid    | item_stall     | item   (angle, last)
//   result   | result_valid  | result_stall   | result (index, length, flags)
//
// A word of n elements takes n item beats (one per cycle), then the comparison:
// n candidate advances plus n element compares for each of the n-1 candidate
// rotations, and a hand-off of the result to the output register. The chain
// shifts one element per cycle past the compare at its head.
// Reset clears the sequencer, the load count and the output valid; the cell
// contents are not reset. item_stall is high outside the load phase; a result
// waiting under result_stall holds the final hand-off, and loading of the next
// word waits for it.
module least_rotation_check #(
	parameter int unsigned MAX_LEN = lrc_pkg::MAX_LEN_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  lrc_pkg::item_t  item,
	output logic            result_valid,
	input  logic            result_stall,
	output lrc_pkg::result_t result
);

	localparam int unsigned IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
	localparam int unsigned IB    = lrc_pkg::INDEX_BITS;
	localparam int unsigned LB    = lrc_pkg::LENGTH_BITS;

	typedef enum logic [1:0] {
		S_LOAD,
		S_ADV,
		S_CMP,
		S_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;     // elements held in the chain
	logic             ovf_q;       // an element was dropped
	logic [CNT_W-1:0] r_q;         // candidate rotation in the b chain
	logic [IDX_W-1:0] step_q;      // element position within one compare
	logic [IDX_W-1:0] best_q;      // start index held in the a chain
	logic             decided_q;   // first differing element already seen
	logic             less_q;      // candidate below best at that element
	logic             res_valid_q;
	lrc_pkg::result_t res_q;

	lrc_pkg::cell_ctl_t             ctl;
	logic [MAX_LEN-1:0]             wr;
	logic [lrc_pkg::ANGLE_BITS-1:0] a_cell [MAX_LEN];
	logic [lrc_pkg::ANGLE_BITS-1:0] b_cell [MAX_LEN];

	logic             accept;
	logic             has_room;
	logic             head_diff;
	logic             head_lt;
	logic             lt_now;
	logic             last_step;
	logic [CNT_W-1:0] r_inc;
	logic             out_free;
	logic [IDX_W+IB-1:0] best_wide;
	logic [CNT_W+LB-1:0] len_wide;

	assign item_stall = (state_q != S_LOAD);
	assign accept     = item_valid && !item_stall;
	assign has_room   = (count_q < CNT_W'(MAX_LEN));

	// Compare the heads of both chains, element 0 is most significant.
	assign head_diff = (a_cell[0] != b_cell[0]);
	assign head_lt   = (b_cell[0] < a_cell[0]);
	assign lt_now    = decided_q ? less_q : (head_diff && head_lt);
	assign last_step = ({1'b0, step_q} == (IDX_W + 1)'(count_q - 1'b1));
	assign r_inc     = r_q + 1'b1;
	assign out_free  = !res_valid_q || !result_stall;

	// Rotate the b chain alone on an advance and both chains on every compare step;
	// on the last step a strictly smaller candidate replaces the best rotation.
	always_comb begin
		ctl = '0;
		case (state_q)
			S_ADV: begin
				ctl.rot_b = 1'b1;
			end
			S_CMP: begin
				ctl.rot_a  = 1'b1;
				ctl.rot_b  = 1'b1;
				ctl.copy_b = last_step && lt_now;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	// Write the arriving element at the fill position.
	always_comb begin
		for (int k = 0; k < MAX_LEN; k++) begin
			wr[k] = accept && (count_q == CNT_W'(k));
		end
	end

	for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
		lrc_cell #(
			.POS   (k),
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.wr       (wr[k]),
			.angle    (item.angle),
			.word_len (count_q),
			.ctl      (ctl),
			.a_nb     (a_cell[(k + 1) % MAX_LEN]),
			.b_nb     (b_cell[(k + 1) % MAX_LEN]),
			.a_head   (a_cell[0]),
			.b_head   (b_cell[0]),
			.a        (a_cell[k]),
			.b        (b_cell[k])
		);
	end

	assign best_wide = {{IB{1'b0}}, best_q};
	assign len_wide  = {{LB{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			r_q         <= '0;
			step_q      <= '0;
			best_q      <= '0;
			decided_q   <= 1'b0;
			less_q      <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// Drop the output beat once taken; the hand-off state refills it itself.
			if (res_valid_q && !result_stall && state_q != S_FIN) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (has_room) begin
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.last) begin
							r_q     <= '0;
							best_q  <= '0;
							state_q <= S_ADV;
						end
					end
				end
				S_ADV: begin
					// Advance the b chain to the next candidate.
					r_q       <= r_inc;
					step_q    <= '0;
					decided_q <= 1'b0;
					less_q    <= 1'b0;
					state_q   <= (r_inc == count_q) ? S_FIN : S_CMP;
				end
				S_CMP: begin
					if (last_step) begin
						if (lt_now) begin
							best_q <= r_q[IDX_W-1:0];
						end
						state_q <= S_ADV;
					end else begin
						step_q <= step_q + 1'b1;
						if (!decided_q && head_diff) begin
							decided_q <= 1'b1;
							less_q    <= head_lt;
						end
					end
				end
				S_FIN: begin
					// Hold until the output register is free.
					if (out_free) begin
						res_valid_q             <= 1'b1;
						res_q.is_least_at_start <= (best_q == '0);
						res_q.least_index       <= best_wide[IB-1:0];
						res_q.word_length       <= len_wide[LB-1:0];
						res_q.too_long          <= ovf_q;
						count_q                 <= '0;
						ovf_q                   <= 1'b0;
						state_q                 <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// The fill count never passes the chain length.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_LEN))
		else $error("load count beyond chain length");

	// A compare always runs on a real candidate inside the word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (r_q != '0 && r_q < count_q))
		else $error("candidate rotation outside the word");

	// The kept start index lies inside the word at hand-off.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> ({1'b0, best_q} < (IDX_W + 1)'(count_q)))
		else $error("best start index outside the word");

	// A new result beat appears only out of the hand-off state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_FIN))
		else $error("result beat without finished compare");

endmodule

### rtl/core/lrc_cell.sv
// lrc_cell: one position of the rotating word chain.
// Holds one element of the best rotation (a) and of the candidate rotation (b).
// Depends on lrc_pkg.
module lrc_cell #(
	parameter int unsigned POS   = 0,
	parameter int unsigned CNT_W = lrc_pkg::LENGTH_BITS
) (
	input  logic                            clk,
	input  logic                            wr,
	input  logic [lrc_pkg::ANGLE_BITS-1:0]  angle,
	input  logic [CNT_W-1:0]                word_len,
	input  lrc_pkg::cell_ctl_t              ctl,
	input  logic [lrc_pkg::ANGLE_BITS-1:0]  a_nb,
	input  logic [lrc_pkg::ANGLE_BITS-1:0]  b_nb,
	input  logic [lrc_pkg::ANGLE_BITS-1:0]  a_head,
	input  logic [lrc_pkg::ANGLE_BITS-1:0]  b_head,
	output logic [lrc_pkg::ANGLE_BITS-1:0]  a,
	output logic [lrc_pkg::ANGLE_BITS-1:0]  b
);

	logic                           is_tail;
	logic [lrc_pkg::ANGLE_BITS-1:0] a_src;
	logic [lrc_pkg::ANGLE_BITS-1:0] b_src;
	logic [lrc_pkg::ANGLE_BITS-1:0] a_q;
	logic [lrc_pkg::ANGLE_BITS-1:0] b_q;

	// The last used position wraps around to the head.
	assign is_tail = (word_len == CNT_W'(POS + 1));
	assign a_src   = is_tail ? a_head : a_nb;
	assign b_src   = is_tail ? b_head : b_nb;

	always_ff @(posedge clk) begin
		if (wr) begin
			a_q <= angle;
			b_q <= angle;
		end else begin
			if (ctl.copy_b) begin
				a_q <= b_src;
			end else if (ctl.rot_a) begin
				a_q <= a_src;
			end
			if (ctl.rot_b) begin
				b_q <= b_src;
			end
		end
	end

	assign a = a_q;
	assign b = b_q;

endmodule

### dv/tb.sv
// tb: self-checking testbench for least_rotation_check.
// Streams words of angles with random idling on both channels, predicts each result
// from its own copy of the loaded word, and checks results in order. Depends on lrc_pkg.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WORD_CAP    = lrc_pkg::MAX_LEN_DEF;
	localparam int unsigned CYCLE_LIMIT = 400000;
	// Worst hand-off after the last beat: the full compare of a longest word plus stalls.
	localparam int unsigned DRAIN_CYCLES = 400;
	localparam int unsigned IDLE_PCT     = 27;
	localparam int unsigned REPORT_MAX   = 10;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_stall;
	lrc_pkg::item_t   item         = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	lrc_pkg::result_t result;

	// Beats still to be offered, and results the model says must come out.
	lrc_pkg::item_t   pending_items[$];
	lrc_pkg::result_t expected_results[$];

	// Model copy of the word being loaded.
	logic [lrc_pkg::ANGLE_BITS-1:0] held_angles [WORD_CAP];
	int unsigned                    held_count   = 0;
	bit                             held_dropped = 1'b0;

	int unsigned beats_queued = 0;
	int unsigned beats_loaded = 0;
	int unsigned results_seen = 0;
	int unsigned failures     = 0;
	int unsigned cycle_count  = 0;

	least_rotation_check DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Order of rotation a against rotation b of the held word: -1 less, 0 equal, 1 greater.
	// Element 0 of each rotation is the most significant.
	function automatic int rotation_order(input int unsigned a, input int unsigned b,
	                                      input int unsigned n);
		logic [lrc_pkg::ANGLE_BITS-1:0] va;
		logic [lrc_pkg::ANGLE_BITS-1:0] vb;
		for (int unsigned i = 0; i < n; i++) begin
			va = held_angles[(a + i) % n];
			vb = held_angles[(b + i) % n];
			if (va < vb)
				return -1;
			if (va > vb)
				return 1;
		end
		return 0;
	endfunction

	// Least rotation of the held word; a later start wins only when strictly smaller,
	// so ties keep the earliest index.
	function automatic lrc_pkg::result_t least_rotation_result();
		lrc_pkg::result_t r;
		int unsigned      best;
		best = 0;
		for (int unsigned s = 1; s < held_count; s++) begin
			if (rotation_order(best, s, held_count) > 0)
				best = s;
		end
		r.is_least_at_start = (best == 0);
		r.least_index       = best[lrc_pkg::INDEX_BITS-1:0];
		r.word_length       = held_count[lrc_pkg::LENGTH_BITS-1:0];
		r.too_long          = held_dropped;
		return r;
	endfunction

	// Fold one accepted beat into the model word; past capacity the angle is dropped,
	// even on the closing beat. The closing beat yields one expected result.
	task automatic load_angle_beat(input lrc_pkg::item_t b);
		if (held_count < WORD_CAP) begin
			held_angles[held_count] = b.angle;
			held_count++;
		end else begin
			held_dropped = 1'b1;
		end
		beats_loaded++;
		if (b.last) begin
			expected_results.push_back(least_rotation_result());
			held_count   = 0;
			held_dropped = 1'b0;
		end
	endtask

	task automatic report_failure(input string what, input lrc_pkg::result_t want,
	                              input lrc_pkg::result_t got);
		failures++;
		if (failures <= REPORT_MAX)
			$display({"mismatch %0d (%s): expected start=%0b idx=%0d len=%0d long=%0b,",
				" got start=%0b idx=%0d len=%0d long=%0b"},
				failures, what, want.is_least_at_start, want.least_index, want.word_length,
				want.too_long, got.is_least_at_start, got.least_index, got.word_length,
				got.too_long);
	endtask

	task automatic check_result_beat(input lrc_pkg::result_t got);
		lrc_pkg::result_t want;
		results_seen++;
		if (expected_results.size() == 0) begin
			report_failure("unexpected result", '0, got);
		end else begin
			want = expected_results.pop_front();
			if (got.is_least_at_start !== want.is_least_at_start ||
			    got.least_index !== want.least_index ||
			    got.word_length !== want.word_length ||
			    got.too_long !== want.too_long)
				report_failure("field", want, got);
		end
	endtask

	task automatic queue_angle(input logic [lrc_pkg::ANGLE_BITS-1:0] a, input bit is_last);
		lrc_pkg::item_t b;
		b.angle = a;
		b.last  = is_last;
		pending_items.push_back(b);
		beats_queued++;
	endtask

	// Queue a word of n beats. Styles: 0 full-range random, 1 few distinct extreme values
	// (forces ties and long common prefixes), 2 periodic, 3 all equal.
	task automatic queue_word(input int unsigned n, input int unsigned style);
		logic [lrc_pkg::ANGLE_BITS-1:0] base [WORD_CAP];
		logic [lrc_pkg::ANGLE_BITS-1:0] a;
		int unsigned                    period;
		period = $urandom_range(1, (n < WORD_CAP) ? n : WORD_CAP);
		for (int unsigned i = 0; i < WORD_CAP; i++)
			base[i] = 16'($urandom_range(0, 16'hFFFF));
		for (int unsigned i = 0; i < n; i++) begin
			case (style)
			0: begin
				a = 16'($urandom_range(0, 16'hFFFF));
			end
			1: begin
				case ($urandom_range(0, 4))
				0: a = 16'h0000;
				1: a = 16'h0001;
				2: a = 16'h7FFF;
				3: a = 16'h8000;
				default: a = 16'hFFFF;
				endcase
			end
			2: begin
				a = base[i % period];
			end
			default: begin
				a = base[0];
			end
			endcase
			queue_angle(a, i == n - 1);
		end
	endtask

	// Driver: advance to the next pending beat when the current one was taken or none
	// is up; hold the payload while stalled. Beats 150..299 run with no idling.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				load_angle_beat(item);
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 &&
				    ((beats_loaded >= 150 && beats_loaded < 300) ||
				     $urandom_range(0, 99) >= IDLE_PCT)) begin
					item       <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result beat and draw the next stall.
	// Results 30..69 are taken with no stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				check_result_beat(result);
			result_stall <= !(results_seen >= 30 && results_seen < 70) &&
				($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned r;
		int unsigned n;

		// Directed words.
		// Single-element words at both extremes: index 0, flagged as least at start.
		queue_angle(16'h0000, 1'b1);
		queue_angle(16'hFFFF, 1'b1);
		// Two elements, least rotation at the end, then at the start.
		queue_angle(16'hFFFF, 1'b0);
		queue_angle(16'h0000, 1'b1);
		queue_angle(16'h0000, 1'b0);
		queue_angle(16'hFFFF, 1'b1);
		// Equal elements: every rotation ties, earliest start kept.
		queue_angle(16'h1234, 1'b0);
		queue_angle(16'h1234, 1'b1);
		// Full store in descending order (least start is the last slot), then one more
		// beat carrying the end mark: that beat is dropped and the word flagged too long.
		for (int unsigned i = 0; i < WORD_CAP; i++)
			queue_angle(16'hFFFF - 16'(i * 16'h1111), 1'b0);
		queue_angle(16'h0000, 1'b1);

		// Random words, mostly short; a tenth run past capacity.
		while (beats_queued < 520) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				n = $urandom_range(1, 6);
			else if (r < 90)
				n = $urandom_range(7, WORD_CAP);
			else
				n = $urandom_range(WORD_CAP + 1, WORD_CAP + 4);
			queue_word(n, $urandom_range(0, 3));
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Sample at the falling edge so the driver's updates of this cycle are settled.
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0 && expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### least_rotation_check.f
rtl/core/lrc_pkg.sv
rtl/core/lrc_cell.sv
rtl/core/least_rotation_check.sv
dv/tb.sv
